/* rtl/pvbs_pkg.sv */
package pvbs_pkg;

  // Default section count of one column.
  localparam int unsigned NUM_SECTIONS = 16;

  // Cells in one 16x16x16 section and bytes of a packed nibble section.
  localparam int unsigned CELLS_PER_SECTION = 4096;
  localparam int unsigned NIB_BYTES_PER_SECTION = 2048;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_STORE_READY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESENT_MASK = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTENSION_MASK = 2'd2;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [3:0]  pos_x;
    logic [3:0]  pos_z;
    logic [7:0]  pos_y;
    logic [11:0] new_block_id;
    logic [3:0]  new_meta;
  } req_t;

  typedef struct packed {
    logic [11:0] block_id;
    logic [3:0]  block_meta;
    logic        failed;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;  // latch the request and read all three memories
    logic finish;  // merge and write back, load the result register
  } dp_cmd_t;

endpackage

/* rtl/pvbs_ram.sv */
module pvbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pvbs_datapath.sv */
module pvbs_datapath
  import pvbs_pkg::*;
#(
  parameter int unsigned NumSections = NUM_SECTIONS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  req_t                   in_req_i,
  input  dp_cmd_t                cmd_i,
  output rsp_t                   out_rsp_o
);

  localparam int unsigned IdDepth = NumSections * CELLS_PER_SECTION;
  localparam int unsigned NibDepth = NumSections * NIB_BYTES_PER_SECTION;
  localparam int unsigned IdAw = $clog2(IdDepth);
  localparam int unsigned NibAw = $clog2(NibDepth);
  localparam logic [4:0] SecLimit = 5'(NumSections);

  logic            store_ready_q;
  logic [15:0]     present_mask_q;
  logic [15:0]     extension_mask_q;
  req_t            req_q;
  rsp_t            rsp_q, rsp_d;

  req_t            cur;
  logic [15:0]     id_full;
  logic [14:0]     nib_full;
  logic [IdAw-1:0] id_addr;
  logic [NibAw-1:0] nib_addr;

  logic [3:0]      sec;
  logic            high;
  logic            in_range;
  logic            do_write;
  logic            ext_we;
  logic [3:0]      ext_nib_new;
  logic [7:0]      id_rd, ext_rd, meta_rd;
  logic [7:0]      ext_wr, meta_wr;
  logic [3:0]      ext_old, meta_old;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_ready_q    <= 1'b0;
      present_mask_q   <= '0;
      extension_mask_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STORE_READY:    store_ready_q    <= cfg_data_i[0];
        CFG_PRESENT_MASK:   present_mask_q   <= cfg_data_i;
        CFG_EXTENSION_MASK: extension_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_req_i;
    end
  end

  // The memories are read with the incoming request and written back with the
  // held one, so a single port is enough.
  assign cur      = cmd_i.accept ? in_req_i : req_q;
  assign id_full  = {cur.pos_y, cur.pos_z, cur.pos_x};
  assign nib_full = {cur.pos_y, cur.pos_z, cur.pos_x[3:1]};
  assign id_addr  = id_full[IdAw-1:0];
  assign nib_addr = nib_full[NibAw-1:0];

  assign sec      = req_q.pos_y[7:4];
  assign high     = req_q.pos_x[0];
  assign in_range = {1'b0, sec} < SecLimit;
  assign do_write = store_ready_q && (req_q.command == CMD_WRITE) && in_range;
  assign ext_nib_new = req_q.new_block_id[11:8];
  assign ext_we   = do_write && (ext_nib_new != 4'h0);

  assign ext_old  = high ? ext_rd[7:4] : ext_rd[3:0];
  assign meta_old = high ? meta_rd[7:4] : meta_rd[3:0];
  assign ext_wr   = high ? {ext_nib_new, ext_rd[3:0]} : {ext_rd[7:4], ext_nib_new};
  assign meta_wr  = high ? {req_q.new_meta, meta_rd[3:0]} : {meta_rd[7:4], req_q.new_meta};

  pvbs_ram #(.Width(8), .Depth(IdDepth)) u_id_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.accept || (cmd_i.finish && do_write)),
    .we_i    (cmd_i.finish),
    .addr_i  (id_addr),
    .wdata_i (req_q.new_block_id[7:0]),
    .rdata_o (id_rd)
  );

  pvbs_ram #(.Width(8), .Depth(NibDepth)) u_ext_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.accept || (cmd_i.finish && ext_we)),
    .we_i    (cmd_i.finish),
    .addr_i  (nib_addr),
    .wdata_i (ext_wr),
    .rdata_o (ext_rd)
  );

  pvbs_ram #(.Width(8), .Depth(NibDepth)) u_meta_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.accept || (cmd_i.finish && do_write)),
    .we_i    (cmd_i.finish),
    .addr_i  (nib_addr),
    .wdata_i (meta_wr),
    .rdata_o (meta_rd)
  );

  always_comb begin
    rsp_d = '0;
    if (!store_ready_q) begin
      rsp_d.failed = 1'b1;
    end else if ((req_q.command == CMD_READ) && in_range && present_mask_q[sec]) begin
      rsp_d.block_id   = {(extension_mask_q[sec] ? ext_old : 4'h0), id_rd};
      rsp_d.block_meta = meta_old;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_rsp_o = rsp_q;

endmodule

/* rtl/pvbs_ctrl.sv */
module pvbs_ctrl
  import pvbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_FINISH = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o   = (state_q == S_IDLE);
  assign slot_free    = !out_valid_q || out_ready_i;
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.finish = (state_q == S_FINISH) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (cmd_o.accept) state_d = S_FINISH;
      S_FINISH: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // An accepted request always moves on to the write-back cycle.
  a_accept_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == S_FINISH))
    else $error("accepted request did not reach the finish state");

  // A new result appears only after a finish cycle.
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.finish))
    else $error("result became valid without a finish cycle");

  // Finishing never overwrites a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while still pending");

endmodule

/* rtl/packed_voxel_block_store_top.sv */
// An accepted request moves to the finish state, which loads the result register when the
// output is free. No new request is taken until the last has finished: the single-port
// memories are read on acceptance and the merged nibble bytes written back on finish.
// The result register lets a new request be accepted while an earlier result waits.
// Reset (rst_ni, asynchronous, active low) clears the controller and all configuration
// registers; the cell memories are not cleared and hold nothing defined until written.
module packed_voxel_block_store_top
  import pvbs_pkg::*;
#(
  parameter int unsigned NumSections = NUM_SECTIONS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // Request channel.
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  req_t                   in_req_i,
  // Result channel.
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rsp_t                   out_rsp_o
);

  // The controller takes each request through an accept and a finish cycle:
  // in the accept cycle all three memories are read at the request's cell, and in
  // the finish cycle the datapath merges the new nibbles into the packed bytes,
  // writes them back and loads the result register. The finish cycle waits
  // while a previous result is still pending on the output.
  dp_cmd_t dp_cmd;

  pvbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd)
  );

  // The datapath holds the configuration registers, the request register, the
  // id, extension and meta memories, and the result register.
  pvbs_datapath #(
    .NumSections (NumSections)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (dp_cmd),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

/* dv/tb_packed_voxel_block_store_top.sv */
`timescale 1ns / 100ps

module tb_packed_voxel_block_store_top;
  import pvbs_pkg::*;

  // Clock, reset and the ports of the block.
  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  req_t                   in_req_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  rsp_t                   out_rsp_o;

  packed_voxel_block_store_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // The testbench's own copy of the configuration registers. They only change
  // while the block is idle, so every accepted request is predicted with the
  // settings that the block itself uses for it.
  logic        cfg_ready;
  logic [15:0] cfg_present;
  logic [15:0] cfg_extension;

  // Cell contents as the predictor sees them, keyed by the 16-bit cell number
  // {pos_y, pos_z, pos_x}. The section is the top four bits of that number and
  // the offset within the section is the low twelve. Nibbles are kept per cell;
  // the packing of two cells into one byte in the block must not let a write to
  // one cell disturb its partner, and the checks below catch it if it does.
  // A missing key means the cell part was never written.
  logic [7:0]  cell_id_byte [bit [15:0]];
  logic [3:0]  cell_ext_nib [bit [15:0]];
  logic [3:0]  cell_meta_nib [bit [15:0]];
  bit   [15:0] written_cells [$];

  // Results still owed by the block, oldest first.
  rsp_t pending_cell_results [$];

  // Traffic shaping, changed by the test tasks and read by the driving processes.
  bit source_throttle;
  bit sink_throttle;
  int unsigned sink_hold_cycles;

  // Bookkeeping for the checks and the closing summary.
  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned reads_sent;
  int unsigned writes_sent;
  int unsigned failed_predicted;
  int unsigned absent_reads;
  int unsigned config_settings;

  // 125 MHz clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Gap lengths for both sides: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A cell may be read from a present section only when every part that the
  // read uses holds a written value. The extension nibble only counts when the
  // section has extension storage, since otherwise it is not looked at.
  function automatic bit cell_readable(bit [15:0] cell_no);
    if (!cell_id_byte.exists(cell_no) || !cell_meta_nib.exists(cell_no)) return 1'b0;
    if (cfg_extension[cell_no[15:12]] && !cell_ext_nib.exists(cell_no)) return 1'b0;
    return 1'b1;
  endfunction

  // Predicts the single result of one accepted request and applies a write to
  // the predicted cell contents. With sixteen sections every section number that
  // pos_y can carry is in range, so the out-of-range case cannot be reached.
  function automatic rsp_t predict_cell_access(req_t req);
    rsp_t        rsp;
    bit   [15:0] cell_no;
    bit   [3:0]  section;
    rsp     = '0;
    cell_no = {req.pos_y, req.pos_z, req.pos_x};
    section = req.pos_y[7:4];
    if (!cfg_ready) begin
      // A store that is not ready refuses everything and keeps nothing.
      rsp.failed = 1'b1;
      failed_predicted++;
      return rsp;
    end
    if (req.command == CMD_READ) begin
      if (!cfg_present[section]) begin
        absent_reads++;
        return rsp;
      end
      rsp.block_id = {4'h0, cell_id_byte[cell_no]};
      if (cfg_extension[section]) rsp.block_id[11:8] = cell_ext_nib[cell_no];
      rsp.block_meta = cell_meta_nib[cell_no];
    end else begin
      // Writes land even in absent sections. A zero extension nibble leaves the
      // stored one as it was.
      if (!cell_id_byte.exists(cell_no)) written_cells.push_back(cell_no);
      cell_id_byte[cell_no]  = req.new_block_id[7:0];
      cell_meta_nib[cell_no] = req.new_meta;
      if (req.new_block_id[11:8] != 4'h0) cell_ext_nib[cell_no] = req.new_block_id[11:8];
    end
    return rsp;
  endfunction

  function automatic req_t build_request(cmd_e cmd, logic [3:0] x, logic [3:0] z,
                                         logic [7:0] y, logic [11:0] id, logic [3:0] meta);
    req_t req;
    req.command      = cmd;
    req.pos_x        = x;
    req.pos_z        = z;
    req.pos_y        = y;
    req.new_block_id = id;
    req.new_meta     = meta;
    return req;
  endfunction

  // Random traffic that keeps coming back to cells already written, and to the
  // partner cell sharing their nibble byte, so that reads return stored data and
  // the packed nibble merges get exercised. A read that would touch a cell not
  // yet fully written in a present section becomes a write to that cell.
  function automatic req_t make_random_request();
    req_t        req;
    bit   [15:0] cell_no;
    int unsigned roll;
    req.command = ($urandom_range(0, 99) < 55) ? CMD_READ : CMD_WRITE;
    roll = $urandom_range(0, 99);
    if (written_cells.size() != 0 && roll < 45)
      cell_no = written_cells[$urandom_range(0, written_cells.size() - 1)];
    else if (written_cells.size() != 0 && roll < 65)
      cell_no = written_cells[$urandom_range(0, written_cells.size() - 1)] ^ 16'h0001;
    else
      cell_no = 16'($urandom_range(0, 16'hFFFF));
    if (req.command == CMD_READ && cfg_ready && cfg_present[cell_no[15:12]] &&
        !cell_readable(cell_no))
      req.command = CMD_WRITE;
    {req.pos_y, req.pos_z, req.pos_x} = cell_no;
    req.new_block_id = 12'($urandom_range(0, 12'hFFF));
    if ($urandom_range(0, 99) < 20) req.new_block_id[11:8] = 4'h0;
    req.new_meta = 4'($urandom_range(0, 15));
    return req;
  endfunction

  // Offers one request and waits for it to be taken. The valid stays high from
  // one request to the next when there is no gap, so it is only ever assigned
  // once per falling edge. The expectation is recorded at the accepting edge.
  task automatic send_request(input req_t req);
    int unsigned gap;
    gap = source_throttle ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (req.command == CMD_READ) reads_sent++;
    else writes_sent++;
    pending_cell_results.push_back(predict_cell_access(req));
  endtask

  // Stops offering requests and waits until the block has answered all of them,
  // then lets the final write-back settle.
  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cell_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Brings the block to idle and then loads all three registers.
  task automatic apply_settings(input logic ready, input logic [15:0] present,
                                input logic [15:0] extension);
    drain_requests();
    write_register(CFG_STORE_READY, {15'h0, ready});
    write_register(CFG_PRESENT_MASK, present);
    write_register(CFG_EXTENSION_MASK, extension);
    cfg_ready     = ready;
    cfg_present   = present;
    cfg_extension = extension;
    config_settings++;
  endtask

  task automatic log_mismatch(input string what, input logic [11:0] want,
                              input logic [11:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on result %0d, %s: expected 0x%h, got 0x%h",
               $realtime, results_seen, what, want, got);
  endtask

  // Result sink. It takes results whenever it is ready, stalls at random while
  // throttled, and honors a long hold-off that it counts down itself.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        sink_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (sink_throttle && $urandom_range(0, 99) < 25) begin
        out_ready_i <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker: every result taken is matched against the oldest
  // expectation, field by field.
  initial begin : result_checker
    rsp_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_cell_results.size() == 0) begin
          log_mismatch("result with no request outstanding", 12'h0, out_rsp_o.block_id);
        end else begin
          want = pending_cell_results.pop_front();
          if (out_rsp_o.block_id !== want.block_id)
            log_mismatch("block_id", want.block_id, out_rsp_o.block_id);
          if (out_rsp_o.block_meta !== want.block_meta)
            log_mismatch("block_meta", {8'h0, want.block_meta}, {8'h0, out_rsp_o.block_meta});
          if (out_rsp_o.failed !== want.failed)
            log_mismatch("failed", {11'h0, want.failed}, {11'h0, out_rsp_o.failed});
        end
        results_seen++;
      end
    end
  end

  // Straight after reset every configuration register is zero, so the store is not
  // ready and both reads and writes must come back failed, with nothing stored.
  task automatic test_not_ready_rejects_all();
    send_request(build_request(CMD_READ, 4'h0, 4'h0, 8'h00, 12'h000, 4'h0));
    send_request(build_request(CMD_WRITE, 4'hF, 4'hF, 8'hFF, 12'hFFF, 4'hF));
    send_request(build_request(CMD_READ, 4'hF, 4'hF, 8'hFF, 12'hFFF, 4'hF));
  endtask

  // Corner cells of the column with all-ones and near-zero data. The top cell
  // gets a nonzero extension nibble so that it is fully defined for the read.
  task automatic test_field_extremes();
    apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
    send_request(build_request(CMD_WRITE, 4'h0, 4'h0, 8'h00, 12'hFFF, 4'hF));
    send_request(build_request(CMD_WRITE, 4'hF, 4'hF, 8'hFF, 12'h100, 4'h0));
    send_request(build_request(CMD_READ, 4'h0, 4'h0, 8'h00, 12'h000, 4'h0));
    send_request(build_request(CMD_READ, 4'hF, 4'hF, 8'hFF, 12'hFFF, 4'hF));
  endtask

  // Two neighbor cells that share one nibble byte, the even one in the low
  // nibble and the odd one in the high nibble. Rewriting the even cell with a
  // zero extension nibble must keep its old extension and leave the odd cell
  // alone.
  task automatic test_nibble_packing();
    send_request(build_request(CMD_WRITE, 4'h2, 4'h5, 8'h37, 12'h3A5, 4'h9));
    send_request(build_request(CMD_WRITE, 4'h3, 4'h5, 8'h37, 12'hC5A, 4'h6));
    send_request(build_request(CMD_READ, 4'h2, 4'h5, 8'h37, 12'h000, 4'h0));
    send_request(build_request(CMD_READ, 4'h3, 4'h5, 8'h37, 12'h000, 4'h0));
    send_request(build_request(CMD_WRITE, 4'h2, 4'h5, 8'h37, 12'h0EE, 4'hF));
    send_request(build_request(CMD_READ, 4'h2, 4'h5, 8'h37, 12'h000, 4'h0));
    send_request(build_request(CMD_READ, 4'h3, 4'h5, 8'h37, 12'h000, 4'h0));
  endtask

  // Section 3 absent and section 5 without extension storage. A write into
  // the absent section is still kept and shows up once the section is present;
  // the extension nibble of section 5 reappears once its storage is enabled.
  task automatic test_section_masks();
    apply_settings(1'b1, 16'hFFF7, 16'hFFDF);
    send_request(build_request(CMD_WRITE, 4'h1, 4'h1, 8'h31, 12'h477, 4'h2));
    send_request(build_request(CMD_READ, 4'h1, 4'h1, 8'h31, 12'h000, 4'h0));
    send_request(build_request(CMD_WRITE, 4'h4, 4'h4, 8'h52, 12'h9AB, 4'h3));
    send_request(build_request(CMD_READ, 4'h4, 4'h4, 8'h52, 12'h000, 4'h0));
    apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
    send_request(build_request(CMD_READ, 4'h1, 4'h1, 8'h31, 12'h000, 4'h0));
    send_request(build_request(CMD_READ, 4'h4, 4'h4, 8'h52, 12'h000, 4'h0));
  endtask

  task automatic run_random_phase(input int unsigned count);
    repeat (count) send_request(make_random_request());
  endtask

  // Random traffic under a series of settings: everything enabled, random
  // masks, the all-zero masks, a store that is not ready, and a stretch at full
  // rate with neither side idling.
  task automatic test_random_traffic();
    source_throttle = 1'b1;
    sink_throttle   = 1'b1;
    apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
    run_random_phase(480);
    apply_settings(1'b1, 16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
    run_random_phase(300);
    apply_settings(1'b1, 16'h0000, 16'h0000);
    run_random_phase(150);
    apply_settings(1'b0, 16'hFFFF, 16'hFFFF);
    run_random_phase(100);
    source_throttle = 1'b0;
    sink_throttle   = 1'b0;
    apply_settings(1'b1, 16'hFFFF, 16'h0000);
    run_random_phase(200);
    source_throttle = 1'b1;
    sink_throttle   = 1'b1;
    apply_settings(1'b1, 16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
    run_random_phase(300);
    apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
    run_random_phase(120);
  endtask

  // The sink holds off for a long stretch while requests keep coming back to
  // back, so the result register and the request register fill and the input stalls.
  task automatic test_output_backpressure();
    source_throttle  = 1'b0;
    sink_throttle    = 1'b0;
    sink_hold_cycles = 100;
    run_random_phase(30);
    sink_throttle = 1'b1;
  endtask

  initial begin : test_sequence
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_STORE_READY;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    in_req_i         = '0;
    cfg_ready        = 1'b0;
    cfg_present      = '0;
    cfg_extension    = '0;
    source_throttle  = 1'b1;
    sink_throttle    = 1'b1;
    sink_hold_cycles = 0;
    mismatch_count   = 0;
    results_seen     = 0;
    reads_sent       = 0;
    writes_sent      = 0;
    failed_predicted = 0;
    absent_reads     = 0;
    config_settings  = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_not_ready_rejects_all();
    test_field_extremes();
    test_nibble_packing();
    test_section_masks();
    test_random_traffic();
    test_output_backpressure();

    drain_requests();
    repeat (10) @(posedge clk_i);

    $display("Checked %0d results: %0d reads, %0d writes, %0d refused by a store not ready,",
             results_seen, reads_sent, writes_sent, failed_predicted);
    $display("%0d reads of absent sections, %0d cells written, %0d register settings.",
             absent_reads, written_cells.size(), config_settings);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, every gap and stall at its
  // longest.
  initial begin : watchdog
    #4_000_000;
    $display("Timeout with %0d results still outstanding.", pending_cell_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* packed_voxel_block_store_top.f */
rtl/pvbs_pkg.sv
rtl/pvbs_ram.sv
rtl/pvbs_datapath.sv
rtl/pvbs_ctrl.sv
rtl/packed_voxel_block_store_top.sv
dv/tb_packed_voxel_block_store_top.sv
